[sv/fc14_pkg.sv]
package fc14_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int POS_W       = 4;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int COUNT_W     = 3;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [BLOCK_WORDS-1:0] block_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0_1  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_2_3  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_4_5  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_6_7  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_256  = 3'd5;

   // "expand 32-byte k" / "expand 16-byte k", little-endian words
   localparam word_type EXPAND_W0     = 32'h6170_7865;
   localparam word_type EXPAND_W1_256 = 32'h3320_646e;
   localparam word_type EXPAND_W1_128 = 32'h3120_646e;
   localparam word_type EXPAND_W2_256 = 32'h7962_2d32;
   localparam word_type EXPAND_W2_128 = 32'h7962_2d36;
   localparam word_type EXPAND_W3     = 32'h6b20_6574;

   // sub-step of one quarter-round on the shared ARX unit
   typedef logic [1:0] arx_step_type;
   localparam arx_step_type STEP_0 = 2'd0;   // d+=e, c^=d, b=rotl(b+c,10)
   localparam arx_step_type STEP_1 = 2'd1;   // a+=b, e^=a, d=rotl(d+e,27)
   localparam arx_step_type STEP_2 = 2'd2;   // c+=d, b^=c, a=rotl(a+b,8)

   typedef struct packed {
      arx_step_type step;
      word_type     x;
      word_type     y;
      word_type     z;
      word_type     w;
   } arx_in_type;

   typedef struct packed {
      word_type x;
      word_type z;
      word_type w;
   } arx_out_type;

   function automatic block_type init_block(
      input logic [63:0] key_0_1,
      input logic [63:0] key_2_3,
      input logic [63:0] key_4_5,
      input logic [63:0] key_6_7,
      input logic [63:0] nonce,
      input logic [63:0] counter,
      input logic        key_256
   );
      block_type   blk;
      logic [63:0] hi_a;
      logic [63:0] hi_b;
      hi_a    = key_256 ? key_4_5 : key_0_1;
      hi_b    = key_256 ? key_6_7 : key_2_3;
      blk[0]  = key_0_1[31:0];
      blk[1]  = key_0_1[63:32];
      blk[2]  = key_2_3[31:0];
      blk[3]  = key_2_3[63:32];
      blk[4]  = counter[31:0];
      blk[5]  = counter[63:32];
      blk[6]  = EXPAND_W0;
      blk[7]  = key_256 ? EXPAND_W1_256 : EXPAND_W1_128;
      blk[8]  = hi_a[31:0];
      blk[9]  = hi_a[63:32];
      blk[10] = hi_b[31:0];
      blk[11] = hi_b[63:32];
      blk[12] = nonce[31:0];
      blk[13] = nonce[63:32];
      blk[14] = key_256 ? EXPAND_W2_256 : EXPAND_W2_128;
      blk[15] = EXPAND_W3;
      return blk;
   endfunction

endpackage

[sv/fc14_ifs.sv]
interface fc14_req_if;
   logic                          valid;
   logic                          ready;
   fc14_pkg::word_type            in_word;
   logic [fc14_pkg::COUNT_W-1:0]  byte_count;
   logic                          end_of_message;

   modport source (output valid, output in_word, output byte_count, output end_of_message,
                   input ready);
   modport sink   (input valid, input in_word, input byte_count, input end_of_message,
                   output ready);
endinterface

interface fc14_rsp_if;
   logic               valid;
   logic               ready;
   fc14_pkg::word_type out_word;
   logic               out_end;

   modport source (output valid, output out_word, output out_end, input ready);
   modport sink   (input valid, input out_word, input out_end, output ready);
endinterface

interface fc14_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fc14_pkg::CSR_INDEX_W-1:0]  index;
   logic [fc14_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/fc14_arx_step.sv]
module fc14_arx_step (
   input  fc14_pkg::arx_in_type  arx_in,
   output fc14_pkg::arx_out_type arx_out
);

   fc14_pkg::word_type sum_x;
   fc14_pkg::word_type mix_z;
   fc14_pkg::word_type sum_w;

   always_comb begin
      sum_x = arx_in.x + arx_in.y;
      mix_z = arx_in.z ^ sum_x;
      sum_w = arx_in.w + mix_z;
      arx_out.x = sum_x;
      arx_out.z = mix_z;
      case (arx_in.step)
         fc14_pkg::STEP_0: arx_out.w = {sum_w[21:0], sum_w[31:22]};
         fc14_pkg::STEP_1: arx_out.w = {sum_w[4:0],  sum_w[31:5]};
         fc14_pkg::STEP_2: arx_out.w = {sum_w[23:0], sum_w[31:24]};
         default:          arx_out.w = sum_w;
      endcase
   end

endmodule

[sv/arx_stream_cipher_14_rounds_unit.sv]
// Channel | Dir | Payload                                  | Handshake
// req     | in  | in_word[31:0], byte_count[2:0], end_of_message | valid/ready
// rsp     | out | out_word[31:0], out_end                  | valid/ready
// csr     | in  | index[2:0], data[63:0]                   | valid/ready, always ready
//
// One word at a time. A word inside a live keystream block is accepted, then
// loaded into the result register. A word that opens a new block first runs
// ceil(ROUND_COUNT/2) double rounds: the single ARX unit runs one third of
// a quarter-round per cycle. Synchronous reset clears all control state and
// the key and nonce registers and selects 256-bit keys. A stalled rsp holds
// the block in its result state; req is not ready again until the result
// register has been loaded.
module arx_stream_cipher_14_rounds_unit #(
   parameter int ROUND_COUNT = 14
) (
   input logic         clock,
   input logic         reset,
   fc14_req_if.sink    req,
   fc14_rsp_if.source  rsp,
   fc14_csr_if.sink    csr
);

   localparam int DR_COUNT = (ROUND_COUNT + 1) / 2;
   localparam int DR_W     = (DR_COUNT > 1) ? $clog2(DR_COUNT) : 1;
   localparam logic [DR_W-1:0] DR_LAST = DR_W'(DR_COUNT - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_OUT   = 2'd2;

   localparam logic [2:0] QR_LAST_COL  = 3'd3;
   localparam logic [2:0] QR_LAST_DIAG = 3'd7;

   logic [1:0]                   state_ff, state_in;
   fc14_pkg::arx_step_type       step_ff, step_in;
   logic [2:0]                   qr_ff, qr_in;
   logic [DR_W-1:0]              dr_ff, dr_in;
   logic [63:0]                  key01_ff, key01_in;
   logic [63:0]                  key23_ff, key23_in;
   logic [63:0]                  key45_ff, key45_in;
   logic [63:0]                  key67_ff, key67_in;
   logic [63:0]                  nonce_ff, nonce_in;
   logic                         key256_ff, key256_in;
   logic [63:0]                  counter_ff, counter_in;
   logic [63:0]                  gen_ctr_ff, gen_ctr_in;
   logic [fc14_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic                         blk_valid_ff, blk_valid_in;
   fc14_pkg::block_type          work_ff, work_in;
   fc14_pkg::word_type           item_word_ff, item_word_in;
   logic [fc14_pkg::COUNT_W-1:0] item_cnt_ff, item_cnt_in;
   logic                         item_eom_ff, item_eom_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   fc14_pkg::word_type           rsp_word_ff, rsp_word_in;
   logic                         rsp_end_ff, rsp_end_in;

   fc14_pkg::arx_in_type         arx_in;
   fc14_pkg::arx_out_type        arx_out;
   fc14_pkg::block_type          qr_upd;
   fc14_pkg::block_type          qr_rot;
   fc14_pkg::block_type          init_load;
   fc14_pkg::block_type          init_out;
   logic [1:0]                   row_shift [4];
   logic [1:0]                   col_idx;
   fc14_pkg::word_type           ks_word;
   fc14_pkg::word_type           byte_mask;
   logic                         req_xfer;
   logic                         rsp_free;

   fc14_arx_step u_arx (
      .arx_in  (arx_in),
      .arx_out (arx_out)
   );

   assign req.ready  = (state_ff == ST_IDLE);
   assign csr.ready  = 1'b1;
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.out_word = rsp_word_ff;
   assign rsp.out_end  = rsp_end_ff;

   assign req_xfer = req.valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   assign init_load = fc14_pkg::init_block(key01_ff, key23_ff, key45_ff, key67_ff,
                                           nonce_ff, counter_ff, key256_ff);
   assign init_out  = fc14_pkg::init_block(key01_ff, key23_ff, key45_ff, key67_ff,
                                           nonce_ff, gen_ctr_ff, key256_ff);
   assign ks_word   = work_ff[pos_ff] + init_out[pos_ff];

   always_comb begin
      case (item_cnt_ff)
         3'd0:    byte_mask = 32'h0000_0000;
         3'd1:    byte_mask = 32'h0000_00ff;
         3'd2:    byte_mask = 32'h0000_ffff;
         3'd3:    byte_mask = 32'h00ff_ffff;
         default: byte_mask = 32'hffff_ffff;
      endcase
   end

   // Quarter-round always works on column 0 (a=0, b=4, c=8, d=12, e=3);
   // rows rotate after each quarter-round to bring the next column or
   // diagonal into place.
   always_comb begin
      qr_upd = work_ff;
      arx_in.step = step_ff;
      case (step_ff)
         fc14_pkg::STEP_0: begin
            arx_in.x = work_ff[12];
            arx_in.y = work_ff[3];
            arx_in.z = work_ff[8];
            arx_in.w = work_ff[4];
            qr_upd[12] = arx_out.x;
            qr_upd[8]  = arx_out.z;
            qr_upd[4]  = arx_out.w;
         end
         fc14_pkg::STEP_1: begin
            arx_in.x = work_ff[0];
            arx_in.y = work_ff[4];
            arx_in.z = work_ff[3];
            arx_in.w = work_ff[12];
            qr_upd[0]  = arx_out.x;
            qr_upd[3]  = arx_out.z;
            qr_upd[12] = arx_out.w;
         end
         default: begin
            arx_in.x = work_ff[8];
            arx_in.y = work_ff[12];
            arx_in.z = work_ff[4];
            arx_in.w = work_ff[0];
            qr_upd[8] = arx_out.x;
            qr_upd[4] = arx_out.z;
            qr_upd[0] = arx_out.w;
         end
      endcase

      // left rotation per row; diagonalize after the columns, undo after the diagonals
      case (qr_ff)
         QR_LAST_COL: begin
            row_shift[0] = 2'd1;
            row_shift[1] = 2'd2;
            row_shift[2] = 2'd3;
            row_shift[3] = 2'd0;
         end
         QR_LAST_DIAG: begin
            row_shift[0] = 2'd1;
            row_shift[1] = 2'd0;
            row_shift[2] = 2'd3;
            row_shift[3] = 2'd2;
         end
         default: begin
            row_shift[0] = 2'd1;
            row_shift[1] = 2'd1;
            row_shift[2] = 2'd1;
            row_shift[3] = 2'd1;
         end
      endcase

      col_idx = 2'd0;
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            col_idx = 2'(c) + row_shift[r];
            qr_rot[r*4 + c] = qr_upd[r*4 + int'(col_idx)];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      qr_in        = qr_ff;
      dr_in        = dr_ff;
      key01_in     = key01_ff;
      key23_in     = key23_ff;
      key45_in     = key45_ff;
      key67_in     = key67_ff;
      nonce_in     = nonce_ff;
      key256_in    = key256_ff;
      counter_in   = counter_ff;
      gen_ctr_in   = gen_ctr_ff;
      pos_in       = pos_ff;
      blk_valid_in = blk_valid_ff;
      work_in      = work_ff;
      item_word_in = item_word_ff;
      item_cnt_in  = item_cnt_ff;
      item_eom_in  = item_eom_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_end_in   = rsp_end_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               item_word_in = req.in_word;
               item_cnt_in  = req.byte_count;
               item_eom_in  = req.end_of_message;
               if (blk_valid_ff) begin
                  state_in = ST_OUT;
               end else begin
                  work_in      = init_load;
                  gen_ctr_in   = counter_ff;
                  counter_in   = counter_ff + 64'd1;
                  pos_in       = '0;
                  blk_valid_in = 1'b1;
                  step_in      = fc14_pkg::STEP_0;
                  qr_in        = '0;
                  dr_in        = '0;
                  state_in     = ST_ROUND;
               end
            end
         end
         ST_ROUND: begin
            if (step_ff == fc14_pkg::STEP_2) begin
               work_in = qr_rot;
               step_in = fc14_pkg::STEP_0;
               qr_in   = qr_ff + 3'd1;
               if (qr_ff == QR_LAST_DIAG) begin
                  if (dr_ff == DR_LAST) begin
                     state_in = ST_OUT;
                  end else begin
                     dr_in = dr_ff + DR_W'(1);
                  end
               end
            end else begin
               work_in = qr_upd;
               step_in = step_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = (item_word_ff ^ ks_word) & byte_mask;
               rsp_end_in   = item_eom_ff;
               pos_in       = pos_ff + 4'd1;
               if (pos_ff == 4'hf || item_eom_ff) begin
                  blk_valid_in = 1'b0;
               end
               if (item_eom_ff) begin
                  pos_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // writes must arrive only while idle; the block itself does not enforce this
      if (csr.valid) begin
         case (csr.index)
            fc14_pkg::CSR_KEY_0_1: begin
               key01_in     = csr.data;
               pos_in       = '0;
               blk_valid_in = 1'b0;
            end
            fc14_pkg::CSR_KEY_2_3: begin
               key23_in     = csr.data;
               pos_in       = '0;
               blk_valid_in = 1'b0;
            end
            fc14_pkg::CSR_KEY_4_5: begin
               key45_in     = csr.data;
               pos_in       = '0;
               blk_valid_in = 1'b0;
            end
            fc14_pkg::CSR_KEY_6_7: begin
               key67_in     = csr.data;
               pos_in       = '0;
               blk_valid_in = 1'b0;
            end
            fc14_pkg::CSR_NONCE: begin
               nonce_in     = csr.data;
               counter_in   = '0;
               pos_in       = '0;
               blk_valid_in = 1'b0;
            end
            fc14_pkg::CSR_KEY_256: begin
               key256_in    = csr.data[0];
               pos_in       = '0;
               blk_valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= fc14_pkg::STEP_0;
         qr_ff        <= '0;
         dr_ff        <= '0;
         key01_ff     <= '0;
         key23_ff     <= '0;
         key45_ff     <= '0;
         key67_ff     <= '0;
         nonce_ff     <= '0;
         key256_ff    <= 1'b1;
         counter_ff   <= '0;
         pos_ff       <= '0;
         blk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         qr_ff        <= qr_in;
         dr_ff        <= dr_in;
         key01_ff     <= key01_in;
         key23_ff     <= key23_in;
         key45_ff     <= key45_in;
         key67_ff     <= key67_in;
         nonce_ff     <= nonce_in;
         key256_ff    <= key256_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         blk_valid_ff <= blk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_ctr_ff   <= gen_ctr_in;
      work_ff      <= work_in;
      item_word_ff <= item_word_in;
      item_cnt_ff  <= item_cnt_in;
      item_eom_ff  <= item_eom_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_end_ff   <= rsp_end_in;
   end

endmodule

[tb/fc14_keystream_check.sv]
module fc14_keystream_check #(
   parameter int ROUND_COUNT = 14
) (
   input  logic clock,
   input  logic reset,
   fc14_req_if  req,
   fc14_rsp_if  rsp,
   fc14_csr_if  csr,
   output int   mismatch_count,
   output int   words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import fc14_pkg::*;

   typedef struct packed {
      word_type word;
      logic     last;
   } cipher_word_type;

   // shadow of the register file and of the keystream position
   logic [63:0]     key01, key23, key45, key67, nonce;
   logic            wide_key;
   block_type       keystream;
   logic [63:0]     block_count;
   logic [3:0]      word_pos;
   logic            stream_live;
   cipher_word_type expected_q[$];

   function automatic word_type rotl(word_type v, int n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   function automatic block_type quarter(block_type w, int a, int b, int c, int d, int e);
      w[d] = w[d] + w[e];
      w[c] = w[c] ^ w[d];
      w[b] = rotl(w[b] + w[c], 10);
      w[a] = w[a] + w[b];
      w[e] = w[e] ^ w[a];
      w[d] = rotl(w[d] + w[e], 27);
      w[c] = w[c] + w[d];
      w[b] = w[b] ^ w[c];
      w[a] = rotl(w[a] + w[b], 8);
      return w;
   endfunction

   function automatic block_type keystream_for(logic [63:0] ctr);
      block_type   init_w;
      block_type   w;
      block_type   ks;
      logic [63:0] upper_a;
      logic [63:0] upper_b;
      upper_a    = wide_key ? key45 : key01;
      upper_b    = wide_key ? key67 : key23;
      init_w[0]  = key01[31:0];
      init_w[1]  = key01[63:32];
      init_w[2]  = key23[31:0];
      init_w[3]  = key23[63:32];
      init_w[4]  = ctr[31:0];
      init_w[5]  = ctr[63:32];
      init_w[6]  = EXPAND_W0;
      init_w[7]  = wide_key ? EXPAND_W1_256 : EXPAND_W1_128;
      init_w[8]  = upper_a[31:0];
      init_w[9]  = upper_a[63:32];
      init_w[10] = upper_b[31:0];
      init_w[11] = upper_b[63:32];
      init_w[12] = nonce[31:0];
      init_w[13] = nonce[63:32];
      init_w[14] = wide_key ? EXPAND_W2_256 : EXPAND_W2_128;
      init_w[15] = EXPAND_W3;
      w = init_w;
      // odd round counts round up to a whole double round
      for (int r = 0; r < (ROUND_COUNT + 1) / 2; r++) begin
         w = quarter(w, 0, 4, 8, 12, 3);
         w = quarter(w, 1, 5, 9, 13, 0);
         w = quarter(w, 2, 6, 10, 14, 1);
         w = quarter(w, 3, 7, 11, 15, 2);
         w = quarter(w, 0, 5, 10, 15, 3);
         w = quarter(w, 1, 6, 11, 12, 0);
         w = quarter(w, 2, 7, 8, 13, 1);
         w = quarter(w, 3, 4, 9, 14, 2);
      end
      for (int i = 0; i < BLOCK_WORDS; i++)
         ks[i] = w[i] + init_w[i];
      return ks;
   endfunction

   function automatic word_type byte_mask(logic [COUNT_W-1:0] count);
      case (count)
         3'd0:    return 32'h0000_0000;
         3'd1:    return 32'h0000_00ff;
         3'd2:    return 32'h0000_ffff;
         3'd3:    return 32'h00ff_ffff;
         default: return 32'hffff_ffff;
      endcase
   endfunction

   task automatic write_setting(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (index)
         CSR_KEY_0_1: key01 = data;
         CSR_KEY_2_3: key23 = data;
         CSR_KEY_4_5: key45 = data;
         CSR_KEY_6_7: key67 = data;
         CSR_NONCE: begin
            nonce       = data;
            block_count = '0;
         end
         CSR_KEY_256: wide_key = data[0];
         default: return;
      endcase
      word_pos    = '0;
      stream_live = 1'b0;
   endtask

   task automatic predict_word(word_type data, logic [COUNT_W-1:0] count, logic last);
      cipher_word_type item;
      if (!stream_live) begin
         keystream   = keystream_for(block_count);
         block_count = block_count + 64'd1;
         word_pos    = '0;
         stream_live = 1'b1;
      end
      item.word = (data ^ keystream[word_pos]) & byte_mask(count);
      item.last = last;
      expected_q.push_back(item);
      word_pos = word_pos + 4'd1;
      if (word_pos == 4'd0 || last) begin
         word_pos    = '0;
         stream_live = 1'b0;
      end
   endtask

   task automatic log_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      cipher_word_type want;
      if (reset) begin
         key01          = '0;
         key23          = '0;
         key45          = '0;
         key67          = '0;
         nonce          = '0;
         wide_key       = 1'b1;
         block_count    = '0;
         word_pos       = '0;
         stream_live    = 1'b0;
         mismatch_count = 0;
         expected_q.delete();
      end else begin
         if (csr.valid && csr.ready)
            write_setting(csr.index, csr.data);
         if (req.valid && req.ready)
            predict_word(req.in_word, req.byte_count, req.end_of_message);
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               log_mismatch($sformatf("result with nothing expected: word %h end %b",
                                      rsp.out_word, rsp.out_end));
            end else begin
               want = expected_q.pop_front();
               if (rsp.out_word !== want.word)
                  log_mismatch($sformatf("out_word expected %h got %h",
                                         want.word, rsp.out_word));
               if (rsp.out_end !== want.last)
                  log_mismatch($sformatf("out_end expected %b got %b",
                                         want.last, rsp.out_end));
            end
         end
      end
      words_pending <= expected_q.size();
   end

endmodule

[tb/tb_arx_stream_cipher_14_rounds_unit.sv]
module tb_arx_stream_cipher_14_rounds_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import fc14_pkg::*;

   localparam int ROUND_COUNT = 14;
   localparam int PHASE_WORDS = 225;

   // indexes past the register list, writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   words_pending;
   int   gap_pct   = 0;
   int   stall_pct = 0;
   int   words_sent = 0;
   int   csr_writes = 0;

   fc14_req_if req_ch ();
   fc14_rsp_if rsp_ch ();
   fc14_csr_if csr_ch ();

   arx_stream_cipher_14_rounds_unit #(.ROUND_COUNT(ROUND_COUNT)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   fc14_keystream_check #(.ROUND_COUNT(ROUND_COUNT)) keystream_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr            (csr_ch),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #30_000_000;
      $display("timeout with %0d results outstanding", words_pending);
      $display("** arx_stream_cipher_14_rounds_unit: FAILED **");
      $finish;
   end

   function automatic logic [63:0] pick64();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // valid stays high across back-to-back transfers
   task automatic send_word(word_type data, logic [COUNT_W-1:0] count, logic last);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_ch.valid          <= 1'b1;
      req_ch.in_word        <= data;
      req_ch.byte_count     <= count;
      req_ch.end_of_message <= last;
      do @(posedge clock); while (!req_ch.ready);
      words_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_writes++;
   endtask

   task automatic scramble_config();
      write_reg(CSR_KEY_0_1, pick64());
      write_reg(CSR_KEY_2_3, pick64());
      write_reg(CSR_KEY_4_5, pick64());
      write_reg(CSR_KEY_6_7, pick64());
      write_reg(CSR_NONCE, pick64());
      write_reg(CSR_KEY_256, {$urandom, $urandom});
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(1) ? CSR_UNMAPPED_6 : CSR_UNMAPPED_7, pick64());
      csr_ch.valid <= 1'b0;
   endtask

   // mostly well-formed messages; noisy ones get any byte count and stray ends
   task automatic send_message(int len, bit noisy);
      logic [COUNT_W-1:0] count;
      logic               last;
      for (int i = 0; i < len; i++) begin
         last  = (i == len - 1);
         count = last ? 3'($urandom_range(1, 4)) : 3'd4;
         if (noisy) begin
            count = 3'($urandom_range(7));
            last  = last ? 1'($urandom_range(1)) : ($urandom_range(9) == 0);
         end
         send_word($urandom, count, last);
      end
   endtask

   initial begin
      int gap_tab[4];
      int stall_tab[4];
      int target;
      gap_tab   = '{0, 50, 0, 24};
      stall_tab = '{0, 0, 50, 24};
      req_ch.valid          = 1'b0;
      req_ch.in_word        = '0;
      req_ch.byte_count     = '0;
      req_ch.end_of_message = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.index          = '0;
      csr_ch.data           = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero key, 256-bit mode, zero nonce
      send_word(32'h0000_0000, 3'd4, 1'b0);
      send_word(32'hffff_ffff, 3'd4, 1'b0);
      send_word(32'ha5a5_a5a5, 3'd0, 1'b0);
      drain();
      write_reg(CSR_UNMAPPED_6, '1);
      write_reg(CSR_UNMAPPED_7, '1);
      csr_ch.valid <= 1'b0;
      send_word(32'h1234_5678, 3'd5, 1'b0);
      send_word(32'hdead_beef, 3'd7, 1'b1);
      drain();
      write_reg(CSR_KEY_0_1, '1);
      write_reg(CSR_KEY_2_3, '1);
      write_reg(CSR_KEY_4_5, '1);
      write_reg(CSR_KEY_6_7, '1);
      write_reg(CSR_KEY_256, 64'd0);
      write_reg(CSR_NONCE, '1);
      csr_ch.valid <= 1'b0;
      send_word(32'hffff_ffff, 3'd1, 1'b0);
      send_word(32'hffff_ffff, 3'd2, 1'b0);
      send_word(32'hffff_ffff, 3'd3, 1'b1);
      send_word(32'h0000_0000, 3'd6, 1'b0);
      drain();
      // key size write mid-stream restarts at word 0; then cross a block boundary
      write_reg(CSR_KEY_256, '1);
      csr_ch.valid <= 1'b0;
      send_message(17, 1'b0);

      for (int p = 0; p < 4; p++) begin
         gap_pct   = gap_tab[p];
         stall_pct = stall_tab[p];
         drain();
         scramble_config();
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            if ($urandom_range(7) == 0) begin
               drain();
               case ($urandom_range(3))
                  0:       write_reg(CSR_NONCE, pick64());
                  1:       write_reg(CSR_KEY_256, {$urandom, $urandom});
                  2:       write_reg(CSR_KEY_0_1, pick64());
                  default: write_reg(CSR_KEY_6_7, pick64());
               endcase
               csr_ch.valid <= 1'b0;
            end
            send_message(($urandom_range(3) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(1, 16),
                         $urandom_range(9) == 0);
         end
      end

      req_ch.valid <= 1'b0;
      for (int n = 0; n < 20000 && words_pending != 0; n++)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (words_pending != 0)
         $display("%0d expected results never arrived", words_pending);

      $display("covered %0d words with %0d register writes: both key sizes, all byte counts,",
               words_sent, csr_writes);
      $display("message ends, block crossings, nonce and key rewrites, four idle/stall mixes");
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("** arx_stream_cipher_14_rounds_unit: PASSED **");
      end else begin
         $display("** arx_stream_cipher_14_rounds_unit: FAILED **");
      end
      $finish;
   end

endmodule

[arx_stream_cipher_14_rounds_unit.f]
sv/fc14_pkg.sv
sv/fc14_ifs.sv
sv/fc14_arx_step.sv
sv/arx_stream_cipher_14_rounds_unit.sv
tb/fc14_keystream_check.sv
tb/tb_arx_stream_cipher_14_rounds_unit.sv
